// ===== src/tkf_pkg.sv =====
// Shared types, constants and saturation helpers for the tilt Kalman fusion block.
// No dependencies; tkf_lane, tkf_merge and tilt_kalman_fusion import this package.
package tkf_pkg;

  // Number of axes carried by one word (fixed by the port fields).
  localparam int AXES = 2;
  // Default number of fraction bits of the Q format.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [7:0] REG_STEP_TIME   = 8'd0;
  localparam logic [7:0] REG_ANGLE_NOISE = 8'd1;
  localparam logic [7:0] REG_BIAS_NOISE  = 8'd2;
  localparam logic [7:0] REG_MEAS_NOISE  = 8'd3;

  // Register reset values.
  localparam logic [17:0] STEP_TIME_RST   = 18'd32768;
  localparam logic [19:0] ANGLE_NOISE_RST = 20'd32768;
  localparam logic [19:0] BIAS_NOISE_RST  = 20'd6554;
  localparam logic [19:0] MEAS_NOISE_RST  = 20'd1966;

  // Largest angle code.
  localparam logic [8:0] CODE_MAX = 9'd360;

  typedef struct packed {
    logic [17:0] step_time;
    logic [19:0] angle_noise;
    logic [19:0] bias_noise;
    logic [19:0] meas_noise;
  } tkf_cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } tkf_lane_stat_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Saturate a 66-bit signed product to 32 bits.
  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/tkf_in_if.sv =====
// Input channel: one word carries an accelerometer angle and a gyro rate per axis.
// No dependencies.
interface tkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] accel_angle_x;
  logic signed [31:0] gyro_rate_x;
  logic signed [31:0] accel_angle_y;
  logic signed [31:0] gyro_rate_y;

  modport source(output valid, accel_angle_x, gyro_rate_x, accel_angle_y, gyro_rate_y,
                 input ready);
  modport sink(input valid, accel_angle_x, gyro_rate_x, accel_angle_y, gyro_rate_y,
               output ready);
endinterface

// ===== src/tkf_out_if.sv =====
// Output channel: fused angles, biases and angle codes of both axes.
// No dependencies.
interface tkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fused_angle_x;
  logic signed [31:0] fused_angle_y;
  logic signed [31:0] bias_x;
  logic signed [31:0] bias_y;
  logic [8:0]         code_x;
  logic [8:0]         code_y;

  modport source(output valid, fused_angle_x, fused_angle_y, bias_x, bias_y, code_x, code_y,
                 input ready);
  modport sink(input valid, fused_angle_x, fused_angle_y, bias_x, bias_y, code_x, code_y,
               output ready);
endinterface

// ===== src/tkf_cfg_if.sv =====
// Configuration write channel: register index and write data.
// No dependencies.
interface tkf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/tkf_lane.sv =====
// One axis of the filter: state, a shared multiplier step and a serial gain divider.
// Depends on tkf_pkg.
module tkf_lane import tkf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tkf_cfg_t           cfg,
  input  logic               start,
  input  logic               take,
  input  logic signed [31:0] acc_in,
  input  logic signed [31:0] rate_in,
  output tkf_lane_stat_t     stat,
  output logic signed [31:0] angle,
  output logic signed [31:0] bias
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_ACC  = 7'b0000100,
    ST_YS   = 7'b0001000,
    ST_DIVI = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG, OP_DTP11, OP_P00, OP_P11,
    OP_KY0, OP_KY1, OP_P10U, OP_P11U, OP_P00U, OP_P01U
  } op_t;

  state_t state;
  op_t    op;

  logic signed [31:0] p00, p01, p10, p11;
  logic signed [31:0] acc_r, rate_r, sum_r, y_r, k0, k1;
  logic signed [33:0] s_r;
  logic signed [65:0] prod;
  logic signed [32:0] a_op, b_op;
  logic signed [31:0] m;

  logic [33:0]   rem, rem_next, dmag;
  logic [NW-1:0] quo, quo_next;
  logic [CW-1:0] dcnt;
  logic          dsel, dneg, dzero;
  logic [34:0]   rs;
  logic signed [31:0] kres;
  logic signed [31:0] num;

  logic signed [32:0] dt_s;
  assign dt_s = $signed({15'b0, cfg.step_time});

  // Select multiplier operands for the current step.
  always_comb begin
    a_op = dt_s;
    b_op = 33'(p11);
    unique case (op)
      OP_ANG:   b_op = 33'(sat34(34'(rate_r) - 34'(bias)));
      OP_DTP11: b_op = 33'(p11);
      OP_P00:   b_op = 33'(sum_r);
      OP_P11:   b_op = $signed({13'b0, cfg.bias_noise});
      OP_KY0:   begin a_op = 33'(k0); b_op = 33'(y_r); end
      OP_KY1:   begin a_op = 33'(k1); b_op = 33'(y_r); end
      OP_P10U:  begin a_op = 33'(k1); b_op = 33'(p00); end
      OP_P11U:  begin a_op = 33'(k1); b_op = 33'(p01); end
      OP_P00U:  begin a_op = 33'(k0); b_op = 33'(p00); end
      OP_P01U:  begin a_op = 33'(k0); b_op = 33'(p01); end
      default:  b_op = 33'(p11);
    endcase
  end

  // Scale the registered product back to Q format, rounding toward minus infinity.
  assign m = sat66(prod >>> FRAC_BITS);

  // One restoring divide step and the saturated signed gain it ends in.
  assign num = dsel ? p10 : p00;
  always_comb begin
    rs = {rem, quo[NW-1]};
    if (rs >= {1'b0, dmag}) begin
      rem_next = 34'(rs - {1'b0, dmag});
      quo_next = {quo[NW-2:0], 1'b1};
    end else begin
      rem_next = rs[33:0];
      quo_next = {quo[NW-2:0], 1'b0};
    end
    if (dzero) kres = '0;
    else if (!dneg) begin
      if (quo_next > NW'(64'h7FFF_FFFF)) kres = 32'sh7FFF_FFFF;
      else kres = $signed(quo_next[31:0]);
    end else begin
      if (quo_next > NW'(64'h8000_0000)) kres = -32'sh8000_0000;
      else kres = $signed(32'(-quo_next[31:0]));
    end
  end

  // Sequence the predict, gain and update steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_ANG;
      angle <= '0;
      bias  <= '0;
      p00   <= '0;
      p01   <= '0;
      p10   <= '0;
      p11   <= '0;
      dsel  <= 1'b0;
      dcnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            acc_r  <= acc_in;
            rate_r <= rate_in;
            op     <= OP_ANG;
            state  <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= a_op * b_op;
          state <= ST_ACC;
        end
        ST_ACC: begin
          state <= ST_MUL;
          op    <= op_t'(4'(op) + 4'd1);
          unique case (op)
            OP_ANG:   angle <= sat34(34'(angle) + 34'(m));
            OP_DTP11: begin
              sum_r <= sat34(34'(m) - 34'(p01) - 34'(p10)
                             + $signed({14'b0, cfg.angle_noise}));
              p01   <= sat34(34'(p01) - 34'(m));
              p10   <= sat34(34'(p10) - 34'(m));
            end
            OP_P00:   p00 <= sat34(34'(p00) + 34'(m));
            OP_P11: begin
              p11   <= sat34(34'(p11) + 34'(m));
              state <= ST_YS;
            end
            OP_KY0:   angle <= sat34(34'(angle) + 34'(m));
            OP_KY1:   bias  <= sat34(34'(bias) + 34'(m));
            OP_P10U:  p10 <= sat34(34'(p10) - 34'(m));
            OP_P11U:  p11 <= sat34(34'(p11) - 34'(m));
            OP_P00U:  p00 <= sat34(34'(p00) - 34'(m));
            OP_P01U: begin
              p01   <= sat34(34'(p01) - 34'(m));
              state <= ST_DONE;
            end
            default:  state <= ST_DONE;
          endcase
        end
        ST_YS: begin
          y_r   <= sat34(34'(acc_r) - 34'(angle));
          s_r   <= 34'(p00) + $signed({14'b0, cfg.meas_noise});
          dsel  <= 1'b0;
          state <= ST_DIVI;
        end
        ST_DIVI: begin
          quo   <= {(num[31] ? 32'(-num) : 32'(num)), FRAC_BITS'(0)};
          rem   <= '0;
          dmag  <= s_r[33] ? 34'(-s_r) : 34'(s_r);
          dneg  <= num[31] ^ s_r[33];
          dzero <= (s_r == '0);
          dcnt  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          dcnt <= dcnt + 1'b1;
          if (dcnt == CW'(NW - 1)) begin
            if (!dsel) begin
              k0    <= kres;
              dsel  <= 1'b1;
              state <= ST_DIVI;
            end else begin
              k1    <= kres;
              op    <= OP_KY0;
              state <= ST_MUL;
            end
          end
        end
        ST_DONE: begin
          if (take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule

// ===== src/tkf_merge.sv =====
// Merging stage: gathers lane results, forms angle codes, holds the output word.
// Depends on tkf_pkg and tkf_out_if.
module tkf_merge import tkf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               all_done,
  input  logic signed [31:0] angle [AXES],
  input  logic signed [31:0] bias [AXES],
  output logic               take,
  tkf_out_if.source          results
);

  logic [8:0] code [AXES];

  // Shift each angle by 180 degrees, truncate and clamp to the code range.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic signed [33:0] v;
      logic signed [33:0] c;
      v = 34'(angle[i]) + (34'sd180 <<< FRAC_BITS);
      c = v >>> FRAC_BITS;
      if (v < 0) code[i] = '0;
      else if (c > 34'sd360) code[i] = CODE_MAX;
      else code[i] = c[8:0];
    end
  end

  assign take = all_done && (!results.valid || results.ready);

  // Load a finished word when the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (take) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      results.fused_angle_x <= angle[0];
      results.fused_angle_y <= angle[1];
      results.bias_x        <= bias[0];
      results.bias_y        <= bias[1];
      results.code_x        <= code[0];
      results.code_y        <= code[1];
    end
  end

endmodule

// ===== src/tilt_kalman_fusion.sv =====
// Top level of the two-axis tilt Kalman fusion block.
// Depends on tkf_pkg, the channel interfaces, tkf_lane and tkf_merge.
//
// Each input word is filtered by one lane per axis, the lanes running side by
// side; each lane has one multiplier used over ten steps and a serial divider
// that produces one quotient bit per cycle for each of its two gains. A new word
// is accepted as soon as the lanes are idle, even while the previous result
// waits to be taken. Configuration writes are always accepted and must be done
// while idle.
module tilt_kalman_fusion import tkf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  tkf_cfg_if.sink   cfg,
  tkf_in_if.sink    samples,
  tkf_out_if.source results
);

  tkf_cfg_t cfg_regs;

  // Write configuration registers; drop unknown indexes.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.step_time   <= STEP_TIME_RST;
      cfg_regs.angle_noise <= ANGLE_NOISE_RST;
      cfg_regs.bias_noise  <= BIAS_NOISE_RST;
      cfg_regs.meas_noise  <= MEAS_NOISE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STEP_TIME:   cfg_regs.step_time   <= cfg.data[17:0];
        REG_ANGLE_NOISE: cfg_regs.angle_noise <= cfg.data[19:0];
        REG_BIAS_NOISE:  cfg_regs.bias_noise  <= cfg.data[19:0];
        REG_MEAS_NOISE:  cfg_regs.meas_noise  <= cfg.data[19:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] acc_in [AXES];
  logic signed [31:0] rate_in [AXES];
  logic signed [31:0] angle [AXES];
  logic signed [31:0] bias [AXES];
  tkf_lane_stat_t     stat [AXES];
  logic [AXES-1:0]    idle_v, done_v;
  logic               start, take;

  assign acc_in[0]  = samples.accel_angle_x;
  assign rate_in[0] = samples.gyro_rate_x;
  assign acc_in[1]  = samples.accel_angle_y;
  assign rate_in[1] = samples.gyro_rate_y;

  assign samples.ready = &idle_v;
  assign start = samples.valid && samples.ready;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    tkf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg_regs),
      .start   (start),
      .take    (take),
      .acc_in  (acc_in[g]),
      .rate_in (rate_in[g]),
      .stat    (stat[g]),
      .angle   (angle[g]),
      .bias    (bias[g])
    );
    assign idle_v[g] = stat[g].idle;
    assign done_v[g] = stat[g].done;
  end

  tkf_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .all_done (&done_v),
    .angle    (angle),
    .bias     (bias),
    .take     (take),
    .results  (results)
  );

endmodule

// ===== src/tkf_checker.sv =====
// Port-level checks for tilt_kalman_fusion, attached by bind.
// Depends on the channel interfaces.
module tkf_checker (
  input logic       clk,
  input logic       rst,
  tkf_in_if.sink    samples,
  tkf_out_if.source results
);

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> $stable(results.fused_angle_x)
      && $stable(results.bias_y) && $stable(results.code_x))
    else $error("output word changed while stalled");

  // An accepted word keeps the block busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("input ready right after a word was taken");

  // No output word right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("output valid after reset");

endmodule

bind tilt_kalman_fusion tkf_checker u_tkf_checker (
  .clk     (clk),
  .rst     (rst),
  .samples (samples),
  .results (results)
);
